// ===== rtl/hrrs_pkg.sv =====
// shared types and constants for the http request region splitter
package hrrs_pkg;

    localparam int MAX_PACKET_LEN_DEF       = 65535;
    localparam int METHOD_SEARCH_WINDOW_DEF = 16;

    localparam int OFF_W = 16;

    // byte codes
    localparam logic [7:0] BYTE_TLS_HS = 8'h16;
    localparam logic [7:0] BYTE_SP     = 8'h20;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_UC_A   = 8'h41;
    localparam logic [7:0] BYTE_UC_Z   = 8'h5A;

    // method length limits
    localparam int METHOD_MIN = 3;
    localparam int METHOD_MAX = 12;

    // result kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TLS  = 2'd1;
    localparam logic [1:0] KIND_HTTP = 2'd2;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       method_len;
        logic [OFF_W-1:0] uri_start;
        logic [OFF_W-1:0] uri_len;
        logic [OFF_W-1:0] header_start;
        logic [OFF_W-1:0] header_len;
        logic [OFF_W-1:0] body_start;
        logic [OFF_W-1:0] body_len;
        logic             too_long;
    } t_result;

endpackage

// ===== rtl/hrrs_parser.sv =====
// per-byte request parser state and end-of-packet result builder
module hrrs_parser #(
    parameter int MAX_PACKET_LEN       = hrrs_pkg::MAX_PACKET_LEN_DEF,
    parameter int METHOD_SEARCH_WINDOW = hrrs_pkg::METHOD_SEARCH_WINDOW_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output hrrs_pkg::t_result o_result
);
    import hrrs_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_LEN + 1);

    typedef enum logic [2:0] {
        PH_FIRST, PH_METHOD, PH_URI, PH_REQLINE, PH_HEADER, PH_BODY, PH_TLS, PH_NONE
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [3:0]       r_mlen, n_mlen;
    logic [POS_W-1:0] r_uri_end, n_uri_end;
    logic [POS_W-1:0] r_hdr_beg, n_hdr_beg;
    logic [POS_W-1:0] r_hdr_end, n_hdr_end;
    logic [POS_W-1:0] r_body_beg, n_body_beg;
    logic [23:0]      r_recent, n_recent;
    logic [1:0]       r_hcnt, n_hcnt;
    logic             r_ovf, n_ovf;

    always_comb begin
        t_phase     ph;
        logic [7:0] b;
        logic [7:0] p1, p2, p3;
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_mlen     = r_mlen;
        n_uri_end  = r_uri_end;
        n_hdr_beg  = r_hdr_beg;
        n_hdr_end  = r_hdr_end;
        n_body_beg = r_body_beg;
        n_recent   = r_recent;
        n_hcnt     = r_hcnt;
        n_ovf      = r_ovf;
        b  = i_byte;
        p1 = r_recent[7:0];
        p2 = r_recent[15:8];
        p3 = r_recent[23:16];
        ph = r_phase;
        if (!r_ovf) begin
            if (32'(r_pos) >= 32'(MAX_PACKET_LEN)) begin
                n_ovf = 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
                if (ph == PH_FIRST) begin
                    if (b == BYTE_TLS_HS) begin
                        ph      = PH_TLS;
                        n_phase = PH_TLS;
                    end else begin
                        ph      = PH_METHOD;
                        n_phase = PH_METHOD;
                    end
                end
                case (ph)
                    PH_METHOD: begin
                        if (32'(r_pos) >= 32'(METHOD_SEARCH_WINDOW)) begin
                            n_phase = PH_NONE;
                        end else if (b == BYTE_SP) begin
                            if (32'(r_pos) >= 32'(METHOD_MIN) &&
                                32'(r_pos) <= 32'(METHOD_MAX)) begin
                                n_mlen  = r_pos[3:0];
                                n_phase = PH_URI;
                            end else begin
                                n_phase = PH_NONE;
                            end
                        end else if (b < BYTE_UC_A || b > BYTE_UC_Z ||
                                     32'(r_pos) >= 32'(METHOD_MAX)) begin
                            n_phase = PH_NONE;
                        end
                    end
                    PH_URI: begin
                        if (b == BYTE_SP || b == BYTE_CR || b == BYTE_LF) begin
                            n_uri_end = r_pos;
                            if (b == BYTE_LF) begin
                                n_hdr_beg = r_pos + 1'b1;
                                n_recent  = '0;
                                n_hcnt    = '0;
                                n_phase   = PH_HEADER;
                            end else begin
                                n_phase = PH_REQLINE;
                            end
                        end
                    end
                    PH_REQLINE: begin
                        if (b == BYTE_LF) begin
                            n_hdr_beg = r_pos + 1'b1;
                            n_recent  = '0;
                            n_hcnt    = '0;
                            n_phase   = PH_HEADER;
                        end
                    end
                    PH_HEADER: begin
                        if (b == BYTE_LF && r_hcnt >= 2'd1 && p1 == BYTE_LF) begin
                            n_hdr_end  = r_pos - 1'b1;
                            n_body_beg = r_pos + 1'b1;
                            n_phase    = PH_BODY;
                        end else if (b == BYTE_LF && r_hcnt == 2'd3 && p1 == BYTE_CR &&
                                     p2 == BYTE_LF && p3 == BYTE_CR) begin
                            n_hdr_end  = r_pos - 2'd3;
                            n_body_beg = r_pos + 1'b1;
                            n_phase    = PH_BODY;
                        end else begin
                            n_recent = {r_recent[15:0], b};
                            if (r_hcnt != 2'd3) begin
                                n_hcnt = r_hcnt + 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result as seen after the current byte
    always_comb begin
        logic [OFF_W-1:0] len, mlen1, uri_end, hb, he, bb;
        o_result = '0;
        len     = OFF_W'(n_pos);
        mlen1   = OFF_W'(n_mlen) + 1'b1;
        uri_end = OFF_W'(n_uri_end);
        hb      = OFF_W'(n_hdr_beg);
        he      = OFF_W'(n_hdr_end);
        bb      = OFF_W'(n_body_beg);
        if (n_ovf) begin
            o_result.too_long = 1'b1;
        end else if (n_phase == PH_TLS) begin
            o_result.kind = KIND_TLS;
        end else if (n_phase == PH_URI || n_phase == PH_REQLINE ||
                     n_phase == PH_HEADER || n_phase == PH_BODY) begin
            o_result.kind       = KIND_HTTP;
            o_result.method_len = n_mlen;
            if (n_phase != PH_URI) begin
                if (uri_end > mlen1) begin
                    o_result.uri_start = mlen1;
                    o_result.uri_len   = uri_end - mlen1;
                end
                if (n_phase == PH_HEADER && len > hb) begin
                    o_result.header_start = hb;
                    o_result.header_len   = len - hb;
                end
                if (n_phase == PH_BODY) begin
                    if (he > hb) begin
                        o_result.header_start = hb;
                        o_result.header_len   = he - hb;
                    end
                    if (len > bb) begin
                        o_result.body_start = bb;
                        o_result.body_len   = len - bb;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase    <= PH_FIRST;
            r_pos      <= '0;
            r_mlen     <= '0;
            r_uri_end  <= '0;
            r_hdr_beg  <= '0;
            r_hdr_end  <= '0;
            r_body_beg <= '0;
            r_recent   <= '0;
            r_hcnt     <= '0;
            r_ovf      <= 1'b0;
        end else if (i_take) begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_mlen     <= n_mlen;
            r_uri_end  <= n_uri_end;
            r_hdr_beg  <= n_hdr_beg;
            r_hdr_end  <= n_hdr_end;
            r_body_beg <= n_body_beg;
            r_recent   <= n_recent;
            r_hcnt     <= n_hcnt;
            r_ovf      <= n_ovf;
        end
    end

endmodule

// ===== rtl/http_request_region_splitter.sv =====
// top level: input register, request parser and result register
//
// Input channel: one payload byte per transfer on i_data_byte, with
// i_last_byte high on the final byte of a packet (i_valid / o_ready).
// Output channel: one result per packet, offered on o_valid / i_ready,
// carrying kind, method length and the uri, header and body spans as
// byte offsets within the packet, plus the too-long flag.
// Throughput: one byte per cycle while no last byte waits on the result
// register. Every byte passes an input register, then the parser updates
// its state when the byte is taken from there. The result of a packet
// is offered straight from the result register.
// When the receiver stalls, bytes keep flowing until a last byte has to
// wait for the result register; that byte holds in the input register and
// o_ready drops until the pending result is transferred.
// Reset clears the parser state, both valid flags and any partial packet.
module http_request_region_splitter #(
    parameter int MAX_PACKET_LEN       = hrrs_pkg::MAX_PACKET_LEN_DEF,
    parameter int METHOD_SEARCH_WINDOW = hrrs_pkg::METHOD_SEARCH_WINDOW_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data_byte,
    input  logic                       i_last_byte,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [1:0]                 o_kind,
    output logic [3:0]                 o_method_len,
    output logic [hrrs_pkg::OFF_W-1:0] o_uri_start,
    output logic [hrrs_pkg::OFF_W-1:0] o_uri_len,
    output logic [hrrs_pkg::OFF_W-1:0] o_header_start,
    output logic [hrrs_pkg::OFF_W-1:0] o_header_len,
    output logic [hrrs_pkg::OFF_W-1:0] o_body_start,
    output logic [hrrs_pkg::OFF_W-1:0] o_body_len,
    output logic                       o_too_long
);
    import hrrs_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    res;
    logic       out_free;
    logic       take;

    assign out_free = !r_out_valid || i_ready;
    // a last byte only moves on when the result register can take its result
    assign take     = r_in_valid && (!r_in_last || out_free);
    assign o_ready  = !r_in_valid || take;

    hrrs_parser #(
        .MAX_PACKET_LEN       (MAX_PACKET_LEN),
        .METHOD_SEARCH_WINDOW (METHOD_SEARCH_WINDOW)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (take && r_in_last) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_method_len   = r_out.method_len;
    assign o_uri_start    = r_out.uri_start;
    assign o_uri_len      = r_out.uri_len;
    assign o_header_start = r_out.header_start;
    assign o_header_len   = r_out.header_len;
    assign o_body_start   = r_out.body_start;
    assign o_body_len     = r_out.body_len;
    assign o_too_long     = r_out.too_long;

endmodule
